// ===== rtl/mep_pkg.sv =====
// Shared types, constants and helper functions for the Mandelbrot escape pixel unit.
package mep_pkg;

  localparam int MAX_ITER   = 256;
  localparam int ITER_W     = $clog2(MAX_ITER + 1);
  localparam int LUT_IDX_W  = $clog2(MAX_ITER);
  localparam int FRAC_BITS  = 24;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SQ_W       = 41;   // Q8.24 product after the fraction shift
  localparam int MAG_W      = 42;   // x^2 + y^2
  localparam int SUM_W      = 43;   // sums ahead of saturation
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh0000_0000_8000_0000);

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN     = 2'd0,
    REG_Y_ORIGIN     = 2'd1,
    REG_STEP         = 2'd2,
    REG_ESCAPE_LIMIT = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD_MUL,
    ST_COORD_ADD,
    ST_SQUARE,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef logic [7:0] lut_t [MAX_ITER];

  // c8 = largest c with c^4 * MAX_ITER <= 255^4 * n, built at elaboration
  function automatic lut_t build_intensity_lut();
    lut_t               lut;
    longint unsigned    rhs;
    longint unsigned    m;
    longint unsigned    m4;
    int                 lo;
    int                 hi;
    int                 mid;
    for (int n = 0; n < MAX_ITER; n++) begin
      rhs = 64'd255 * 64'd255 * 64'd255 * 64'd255 * longint'(n);
      lo  = 0;
      hi  = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        m   = longint'(mid);
        m4  = m * m * m * m * longint'(MAX_ITER);
        if (m4 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      lut[n] = 8'(lo);
    end
    return lut;
  endfunction

  localparam lut_t INTENSITY_LUT = build_intensity_lut();

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[COORD_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/mep_square_unit.sv =====
// Shared multiplier bank: three registered signed 32x32 products.
module mep_square_unit (
  input  logic                                 clk,
  input  logic signed [mep_pkg::COORD_W-1:0]   a0,
  input  logic signed [mep_pkg::COORD_W-1:0]   b0,
  input  logic signed [mep_pkg::COORD_W-1:0]   a1,
  input  logic signed [mep_pkg::COORD_W-1:0]   b1,
  input  logic signed [mep_pkg::COORD_W-1:0]   a2,
  input  logic signed [mep_pkg::COORD_W-1:0]   b2,
  output logic signed [mep_pkg::PROD_W-1:0]    p0,
  output logic signed [mep_pkg::PROD_W-1:0]    p1,
  output logic signed [mep_pkg::PROD_W-1:0]    p2
);

  always_ff @(posedge clk) begin
    p0 <= mep_pkg::PROD_W'(a0) * mep_pkg::PROD_W'(b0);
    p1 <= mep_pkg::PROD_W'(a1) * mep_pkg::PROD_W'(b1);
    p2 <= mep_pkg::PROD_W'(a2) * mep_pkg::PROD_W'(b2);
  end

endmodule

// ===== rtl/mandelbrot_escape_pixel_unit.sv =====
// Mandelbrot escape-time pixel unit: one pixel in, iteration count and color out.
// One pixel (col, row) is taken per input beat and one result beat comes back for it.
// The point c = origin + step*(col,row) is formed in signed Q8.24 (saturating), then
// z = z*z + c is iterated from z = c; each pass whose |z|^2 stays at or under
// escape_limit is counted, up to MAX_ITER. The color is a fourth-root ramp from a
// constant table: red = c8, green = 64 when c8 is odd, blue = 255 - c8; a point that
// never escapes comes out black with iterations = MAX_ITER. One pixel is in work at a
// time and in_stall stays high until it is finished. Every iteration goes through the
// shared three-multiplier bank: ST_SQUARE forms the registered x^2, y^2 and xy, and
// ST_TEST adds, compares and saturates. The next pixel may be accepted while the previous
// result beat still waits on out_stall. Configuration registers are written with cfg_we,
// cfg_index and cfg_data: 0 x_origin, 1 y_origin, 2 step (31 bits), 3 escape_limit
// (31 bits); write them only while no pixel is in work.
module mandelbrot_escape_pixel_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_W-1:0]         cfg_data,
  // pixel input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [9:0]                        col,
  input  logic [9:0]                        row,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mep_pkg::ITER_W-1:0]        iterations,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue
);

  // configuration registers
  logic signed [31:0] x_origin;
  logic signed [31:0] y_origin;
  logic [30:0]        step;
  logic [30:0]        escape_limit;

  mep_pkg::state_t state;
  mep_pkg::state_t state_next;

  // per-pixel working registers
  logic [9:0]                          col_reg;
  logic [9:0]                          row_reg;
  logic signed [mep_pkg::COORD_W-1:0]  c_real;
  logic signed [mep_pkg::COORD_W-1:0]  c_imag;
  logic signed [mep_pkg::COORD_W-1:0]  z_real;
  logic signed [mep_pkg::COORD_W-1:0]  z_imag;
  logic [mep_pkg::ITER_W-1:0]          iter_count;

  // multiplier bank operands and products
  logic signed [mep_pkg::COORD_W-1:0]  mul_a0, mul_b0, mul_a1, mul_b1, mul_a2, mul_b2;
  logic signed [mep_pkg::PROD_W-1:0]   prod0, prod1, prod2;

  // iteration datapath
  logic signed [mep_pkg::SQ_W-1:0]     x2, y2, xy;
  logic signed [mep_pkg::MAG_W-1:0]    mag;
  logic signed [mep_pkg::MAG_W-1:0]    limit_ext;
  logic                                escaped;
  logic                                last_iter;
  logic [mep_pkg::ITER_W-1:0]          iter_inc;
  logic signed [mep_pkg::SUM_W-1:0]    re_sum, im_sum;
  logic signed [mep_pkg::SUM_W-1:0]    cr_sum, ci_sum;

  // color
  logic [7:0]                          c8;
  logic                                never_escaped;
  logic                                out_free;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin     <= -32'sd30618419;
      y_origin     <= -32'sd6291456;
      step         <= 31'd20972;
      escape_limit <= 31'd1677721600;
    end else if (cfg_we) begin
      case (mep_pkg::reg_index_t'(cfg_index))
        mep_pkg::REG_X_ORIGIN:     x_origin     <= cfg_data;
        mep_pkg::REG_Y_ORIGIN:     y_origin     <= cfg_data;
        mep_pkg::REG_STEP:         step         <= cfg_data[30:0];
        mep_pkg::REG_ESCAPE_LIMIT: escape_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier bank: coordinate products during setup, z products while
  // iterating.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state == mep_pkg::ST_COORD_MUL) begin
      mul_a0 = $signed({1'b0, step});
      mul_b0 = $signed({22'd0, col_reg});
      mul_a1 = $signed({1'b0, step});
      mul_b1 = $signed({22'd0, row_reg});
    end else begin
      mul_a0 = z_real;
      mul_b0 = z_real;
      mul_a1 = z_imag;
      mul_b1 = z_imag;
    end
    mul_a2 = z_real;
    mul_b2 = z_imag;
  end

  mep_square_unit u_square (
    .clk (clk),
    .a0  (mul_a0),
    .b0  (mul_b0),
    .a1  (mul_a1),
    .b1  (mul_b1),
    .a2  (mul_a2),
    .b2  (mul_b2),
    .p0  (prod0),
    .p1  (prod1),
    .p2  (prod2)
  );

  // ---------------------------------------------------------------------------
  // Add / compare / saturate stage
  // ---------------------------------------------------------------------------
  always_comb begin
    // arithmetic shift = floor of the Q8.24 product
    x2 = mep_pkg::SQ_W'(prod0 >>> mep_pkg::FRAC_BITS);
    y2 = mep_pkg::SQ_W'(prod1 >>> mep_pkg::FRAC_BITS);
    xy = mep_pkg::SQ_W'(prod2 >>> mep_pkg::FRAC_BITS);
    mag       = mep_pkg::MAG_W'(x2) + mep_pkg::MAG_W'(y2);
    limit_ext = mep_pkg::MAG_W'($signed({1'b0, escape_limit}));
    escaped   = mag > limit_ext;
    iter_inc  = iter_count + 1'b1;
    last_iter = iter_inc == mep_pkg::ITER_W'(mep_pkg::MAX_ITER);
    re_sum = mep_pkg::SUM_W'(x2) - mep_pkg::SUM_W'(y2) + mep_pkg::SUM_W'(c_real);
    im_sum = mep_pkg::SUM_W'(xy) + mep_pkg::SUM_W'(xy) + mep_pkg::SUM_W'(c_imag);
    // coordinate: origin plus a non-negative product below 2^41
    cr_sum = mep_pkg::SUM_W'(x_origin) + mep_pkg::SUM_W'(prod0);
    ci_sum = mep_pkg::SUM_W'(y_origin) + mep_pkg::SUM_W'(prod1);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != mep_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= mep_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mep_pkg::ST_IDLE:      if (in_valid) state_next = mep_pkg::ST_COORD_MUL;
      mep_pkg::ST_COORD_MUL: state_next = mep_pkg::ST_COORD_ADD;
      mep_pkg::ST_COORD_ADD: state_next = mep_pkg::ST_SQUARE;
      mep_pkg::ST_SQUARE:    state_next = mep_pkg::ST_TEST;
      mep_pkg::ST_TEST: begin
        if (escaped || last_iter) state_next = mep_pkg::ST_DONE;
        else state_next = mep_pkg::ST_SQUARE;
      end
      mep_pkg::ST_DONE:      if (out_free) state_next = mep_pkg::ST_IDLE;
      default:               state_next = mep_pkg::ST_IDLE;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      mep_pkg::ST_IDLE: begin
        col_reg <= col;
        row_reg <= row;
      end
      mep_pkg::ST_COORD_ADD: begin
        c_real     <= mep_pkg::sat32(cr_sum);
        c_imag     <= mep_pkg::sat32(ci_sum);
        z_real     <= mep_pkg::sat32(cr_sum);
        z_imag     <= mep_pkg::sat32(ci_sum);
        iter_count <= '0;
      end
      mep_pkg::ST_TEST: begin
        if (!escaped) begin
          iter_count <= iter_inc;
          z_real     <= mep_pkg::sat32(re_sum);
          z_imag     <= mep_pkg::sat32(im_sum);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Color lookup and result register
  // ---------------------------------------------------------------------------
  assign never_escaped = iter_count == mep_pkg::ITER_W'(mep_pkg::MAX_ITER);
  assign c8 = mep_pkg::INTENSITY_LUT[iter_count[mep_pkg::LUT_IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mep_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mep_pkg::ST_DONE && out_free) begin
      iterations <= iter_count;
      if (never_escaped) begin
        red   <= 8'd0;
        green <= 8'd0;
        blue  <= 8'd0;
      end else begin
        red   <= c8;
        green <= c8[0] ? 8'd64 : 8'd0;
        blue  <= 8'd255 - c8;
      end
    end
  end

endmodule

// ===== tb/sv/mandelbrot_escape_pixel_unit_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel unit.
module mandelbrot_escape_pixel_unit_tb;

  localparam int ITER_MAX      = mep_pkg::MAX_ITER;
  localparam int RANDOM_PIXELS = 1280;
  localparam int VIEW_COUNT    = 8;
  // The slowest pixel runs all MAX_ITER iterations; a long result stall can stack on top.
  // Quiet stretches far beyond that mean the block is hung.
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [31:0] RADIUS2_FOUR = 32'd67108864;      // 4.0 in Q8.24
  localparam longint      Q_MAX        = 64'sd2147483647;
  localparam longint      Q_MIN        = -64'sd2147483648;

  typedef struct packed {
    logic [mep_pkg::ITER_W-1:0] iters;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
  } pixel_result_t;

  // DUT pins; every input starts at a known value
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  mep_pkg::reg_index_t        cfg_index = mep_pkg::REG_X_ORIGIN;
  logic [mep_pkg::CFG_W-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [9:0]                 col       = '0;
  logic [9:0]                 row       = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [mep_pkg::ITER_W-1:0] iterations;
  logic [7:0]                 red;
  logic [7:0]                 green;
  logic [7:0]                 blue;

  // Shadow copy of the register file, reset values of the block
  logic signed [31:0] x_origin_m = -32'sd30618419;
  logic signed [31:0] y_origin_m = -32'sd6291456;
  logic [30:0]        step_m     = 31'd20972;
  logic [30:0]        limit_m    = 31'd1677721600;

  pixel_result_t expected_pixels[$];

  int error_count        = 0;
  int sent_count         = 0;
  int checked_count      = 0;
  int bounded_count      = 0;
  int first_escape_count = 0;
  int view_count         = 0;
  int quiet_cycles       = 0;
  int stall_left         = 0;
  bit idle_on            = 1'b1;   // cleared for stretches of full-rate traffic

  always #5 clk = ~clk;

  mandelbrot_escape_pixel_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .col        (col),
    .row        (row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .iterations (iterations),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_q824(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Escape count plus fourth-root color ramp for one pixel at the current view
  function automatic pixel_result_t predict_escape_color(input logic [9:0] c,
                                                          input logic [9:0] r);
    pixel_result_t res;
    longint        cr;
    longint        ci;
    longint        zr;
    longint        zi;
    longint        x2;
    longint        y2;
    longint        xy;
    longint        rhs;
    int            n;
    int            shade;
    bit            escaped;
    cr = clamp_q824(longint'(x_origin_m) + longint'(step_m) * longint'(c));
    ci = clamp_q824(longint'(y_origin_m) + longint'(step_m) * longint'(r));
    zr = cr;
    zi = ci;
    n = 0;
    escaped = 1'b0;
    while (n < ITER_MAX && !escaped) begin
      // products are exact in 64 bits; >>> floors
      x2 = (zr * zr) >>> mep_pkg::FRAC_BITS;
      y2 = (zi * zi) >>> mep_pkg::FRAC_BITS;
      xy = (zr * zi) >>> mep_pkg::FRAC_BITS;
      if (x2 + y2 > longint'(limit_m)) begin
        escaped = 1'b1;
      end else begin
        n++;
        zr = clamp_q824(x2 - y2 + cr);
        zi = clamp_q824(xy + xy + ci);
      end
    end
    res.iters = mep_pkg::ITER_W'(n);
    res.red   = 8'd0;
    res.green = 8'd0;
    res.blue  = 8'd0;
    if (escaped) begin
      // largest shade with shade^4 * MAX_ITER <= 255^4 * n
      rhs = longint'(255) * 255 * 255 * 255 * n;
      shade = 0;
      for (int k = 1; k < 256; k++) begin
        if (longint'(k) * k * k * k * ITER_MAX <= rhs) shade = k;
      end
      res.red   = 8'(shade);
      res.green = shade[0] ? 8'd64 : 8'd0;
      res.blue  = 8'(255 - shade);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle timing: mostly short, sometimes long
  // ---------------------------------------------------------------------------

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Result-side stall: hold a stall/no-stall decision for a random span
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= idle_span();
      out_stall  <= idle_on && ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: values sampled at the edge, before the DUT updates
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected: iterations %0d rgb %0d/%0d/%0d",
                 $time, iterations, red, green, blue);
      end else begin
        want = expected_pixels.pop_front();
        check_field("iterations", 16'(want.iters), 16'(iterations));
        check_field("red", 16'(want.red), 16'(red));
        check_field("green", 16'(want.green), 16'(green));
        check_field("blue", 16'(want.blue), 16'(blue));
        checked_count++;
        if (want.iters == ITER_MAX) bounded_count++;
        if (want.iters == 0) first_escape_count++;
      end
    end
  end

  // Watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_pixels.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called at a rising edge, all drive with NBAs
  // ---------------------------------------------------------------------------

  // One pixel beat; valid stays up if the next beat follows without a gap
  task automatic send_pixel(input logic [9:0] c, input logic [9:0] r);
    int gap;
    gap = (idle_on && $urandom_range(0, 1) == 1) ? idle_span() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    col      <= c;
    row      <= r;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(predict_escape_color(c, r));
    sent_count++;
  endtask

  // Block is idle once every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic put_reg(input mep_pkg::reg_index_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mep_pkg::REG_X_ORIGIN:     x_origin_m = data;
      mep_pkg::REG_Y_ORIGIN:     y_origin_m = data;
      mep_pkg::REG_STEP:         step_m     = data[30:0];
      mep_pkg::REG_ESCAPE_LIMIT: limit_m    = data[30:0];
      default: ;
    endcase
  endtask

  // New view: all four registers, written only while the unit is idle
  task automatic program_view(input logic [31:0] xo, input logic [31:0] yo,
                              input logic [31:0] st, input logic [31:0] lim);
    wait_for_results();
    put_reg(mep_pkg::REG_X_ORIGIN, xo);
    put_reg(mep_pkg::REG_Y_ORIGIN, yo);
    put_reg(mep_pkg::REG_STEP, st);
    put_reg(mep_pkg::REG_ESCAPE_LIMIT, lim);
    cfg_we <= 1'b0;
    view_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at their reset values; corner indexes including ones past the screen
  task automatic test_reset_view();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd799, 10'd599);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd682, 10'd341);
    send_pixel(10'd341, 10'd682);
  endtask

  // c = 0 never escapes, even with a zero limit: full count, black pixel
  task automatic test_bounded_origin();
    program_view(32'd0, 32'd0, 32'd0, RADIUS2_FOUR);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    program_view(32'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(10'd5, 10'd9);
  endtask

  // Zero limit with c away from the origin: escapes on the first test
  task automatic test_zero_limit();
    program_view(32'sd16777216, 32'd0, 32'd1000, 32'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd799, 10'd599);
  endtask

  // Origin and step at their extremes so origin + step*index clips at the top of the range.
  // Bit 31 of step and limit is written as one and must be dropped.
  task automatic test_coordinate_saturation();
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
  endtask

  // c just inside the widest limit: the first update clips z, the next test escapes
  task automatic test_z_saturation();
    program_view(32'd189582540, 32'd0, 32'd0, 32'h7FFF_FFFF);    // real part clips
    send_pixel(10'd3, 10'd3);
    program_view(32'd134000000, 32'd134000000, 32'd0, 32'h7FFF_FFFF); // imag part clips
    send_pixel(10'd0, 10'd0);
  endtask

  // Classic full view along the real axis: a spread of counts and shades
  task automatic test_color_ramp();
    program_view(-32'sd41943040, -32'sd22020096, 32'd73400, RADIUS2_FOUR);
    send_pixel(10'd100, 10'd300);
    send_pixel(10'd250, 10'd300);
    send_pixel(10'd500, 10'd300);
    send_pixel(10'd560, 10'd300);
    send_pixel(10'd600, 10'd280);
  endtask

  // Several views, random pixels; idling toggles in chunks so some stretches run flat out
  task automatic test_random_views();
    logic [31:0] st;
    logic [9:0]  c;
    logic [9:0]  r;
    int          per_view;
    int          roll;
    per_view = RANDOM_PIXELS / VIEW_COUNT;
    for (int v = 0; v < VIEW_COUNT; v++) begin
      case (v)
        0: program_view(-32'sd30618419, -32'sd6291456, 32'd20972, 32'd1677721600);
        1: program_view(-32'sd41943040, -32'sd22020096, 32'd73400, RADIUS2_FOUR);
        2: begin
          // zoom on the neck near -0.75
          st = $urandom_range(40, 1500);
          program_view(-32'sd12582912 - 400 * st, 32'sd1677722 - 300 * st, st,
                       RADIUS2_FOUR);
        end
        3: program_view($urandom, $urandom, $urandom, $urandom);
        4: program_view($urandom_range(0, 41943040) - 32'd33554432,
                        $urandom_range(0, 25165824) - 32'd16777216,
                        $urandom_range(1000, 90000), $urandom_range(0, 200000000));
        5: begin
          // deep zoom on the spiral region, mostly long iteration runs
          st = $urandom_range(1, 200);
          program_view(-32'sd12499026 - 400 * st, 32'sd1895841 - 300 * st, st,
                       RADIUS2_FOUR);
        end
        6: program_view(-32'sd41943040, -32'sd22020096, 32'd73400, 32'hFFFF_FFFF);
        default: program_view(-32'sd30618419, -32'sd6291456, $urandom_range(0, 30000),
                              RADIUS2_FOUR);
      endcase
      for (int i = 0; i < per_view; i++) begin
        if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          c = $urandom_range(0, 799);
          r = $urandom_range(0, 599);
        end else begin
          c = $urandom_range(0, 1023);
          r = $urandom_range(0, 1023);
        end
        send_pixel(c, r);
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_view();
    test_bounded_origin();
    test_zero_limit();
    test_coordinate_saturation();
    test_z_saturation();
    test_color_ramp();
    test_random_views();

    // drain, then give the pipeline time to show any stray beat
    wait_for_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d pixels over %0d views including clipped coordinates and z.",
             sent_count, view_count + 1);
    $display("Checked %0d results: %0d stayed bounded, %0d escaped on the first test.",
             checked_count, bounded_count, first_escape_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
